@@ hw/rtl/btcc_pkg.sv @@
// Types, codes and reset values shared by the battery thermal charge control block.
package btcc_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 23;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLD_LIMIT         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COOL_LIMIT         = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WARM_LIMIT         = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOT_LIMIT          = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OVERHEAT_LIMIT     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_VOLTAGE_UV    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REDUCED_CURRENT_MA = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEFAULT_CURRENT_MA = 3'd7;

   // Register reset values
   localparam logic signed [11:0] RST_COLD_LIMIT         = -12'sd70;
   localparam logic signed [11:0] RST_COOL_LIMIT         = -12'sd49;
   localparam logic signed [11:0] RST_WARM_LIMIT         = 12'sd440;
   localparam logic signed [11:0] RST_HOT_LIMIT          = 12'sd460;
   localparam logic signed [11:0] RST_OVERHEAT_LIMIT     = 12'sd560;
   localparam logic [22:0]        RST_STOP_VOLTAGE_UV    = 23'd4000000;
   localparam logic [11:0]        RST_REDUCED_CURRENT_MA = 12'd450;
   localparam logic [11:0]        RST_DEFAULT_CURRENT_MA = 12'd1000;

   // Temperature bands, coldest first
   localparam logic [2:0] BAND_TOO_COLD = 3'd0;
   localparam logic [2:0] BAND_COOL     = 3'd1;
   localparam logic [2:0] BAND_NORMAL   = 3'd2;
   localparam logic [2:0] BAND_WARM     = 3'd3;
   localparam logic [2:0] BAND_HOT      = 3'd4;
   localparam logic [2:0] BAND_OVERHEAT = 3'd5;

   // Battery health codes
   localparam logic [1:0] HEALTH_GOOD     = 2'd0;
   localparam logic [1:0] HEALTH_OVERHEAT = 2'd1;
   localparam logic [1:0] HEALTH_COLD     = 2'd2;

   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_REDUCED = 2'd1,
      MODE_STOPPED = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      TRANS_NONE           = 3'd0,
      TRANS_NORMAL_STOP    = 3'd1,
      TRANS_NORMAL_REDUCED = 3'd2,
      TRANS_REDUCED_STOP   = 3'd3,
      TRANS_REDUCED_NORMAL = 3'd4,
      TRANS_STOP_NORMAL    = 3'd5
   } trans_type;

   typedef struct packed {
      logic signed [11:0] cold_limit;
      logic signed [11:0] cool_limit;
      logic signed [11:0] warm_limit;
      logic signed [11:0] hot_limit;
      logic signed [11:0] overheat_limit;
      logic [22:0]        stop_voltage_uv;
      logic [11:0]        reduced_current_ma;
      logic [11:0]        default_current_ma;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic        last_charger;
      logic        pseudo_flag;
      logic [11:0] last_current;
   } ctx_type;

   typedef struct packed {
      logic signed [11:0] temp_dc;
      logic [22:0]        volt_uv;
      logic               charger_present;
      logic               charger_changed;
      logic [11:0]        thermal_limit_ma;
      logic [11:0]        charger_limit_ma;
   } sample_type;

   typedef struct packed {
      mode_type    charge_state;
      trans_type   transition;
      logic        refresh;
      logic        disable_charge;
      logic [11:0] current_limit_ma;
      logic [1:0]  health;
      logic        pseudo_charging;
      logic [2:0]  temp_band;
   } result_type;

endpackage

@@ hw/rtl/battery_thermal_charge_control.sv @@
// Top level of the battery thermal charge control block.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  one battery monitor sample
//   rsp_      out        rsp_valid/rsp_ready  state, transition, limit, health, flags
//   csr_      in         csr_we (no wait)     csr_index selects one of eight registers
//
// One sample per cycle sustained while rsp_ready stays high. A sample goes through the
// input register, then the result register, before its rsp transaction; a stalled result
// can hold it in the input register. The single step of band sort and state update lies
// between those registers.
// Synchronous active-high reset: control state and config registers return to defaults.
// A stalled rsp holds its result; one more sample waits in the input register, then
// req_ready drops until the result is taken.
module battery_thermal_charge_control import btcc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [11:0]         req_temp_dc,
   input  logic [22:0]                req_volt_uv,
   input  logic                       req_charger_present,
   input  logic                       req_charger_changed,
   input  logic [11:0]                req_thermal_limit_ma,
   input  logic [11:0]                req_charger_limit_ma,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_charge_state,
   output logic [2:0]                 rsp_transition,
   output logic                       rsp_refresh,
   output logic                       rsp_disable_charge,
   output logic [11:0]                rsp_current_limit_ma,
   output logic [1:0]                 rsp_health,
   output logic                       rsp_pseudo_charging,
   output logic [2:0]                 rsp_temp_band,

   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   ctx_type    ctx_ff;
   ctx_type    ctx_in;
   sample_type in_sample_ff;
   result_type rsp_result_ff;
   result_type step_result;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_accept;
   logic       advance;

   // Move the held sample forward whenever the result register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Configuration registers; the user must write only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cold_limit         <= RST_COLD_LIMIT;
         cfg_ff.cool_limit         <= RST_COOL_LIMIT;
         cfg_ff.warm_limit         <= RST_WARM_LIMIT;
         cfg_ff.hot_limit          <= RST_HOT_LIMIT;
         cfg_ff.overheat_limit     <= RST_OVERHEAT_LIMIT;
         cfg_ff.stop_voltage_uv    <= RST_STOP_VOLTAGE_UV;
         cfg_ff.reduced_current_ma <= RST_REDUCED_CURRENT_MA;
         cfg_ff.default_current_ma <= RST_DEFAULT_CURRENT_MA;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLD_LIMIT:         cfg_ff.cold_limit         <= $signed(csr_wdata[11:0]);
            CSR_COOL_LIMIT:         cfg_ff.cool_limit         <= $signed(csr_wdata[11:0]);
            CSR_WARM_LIMIT:         cfg_ff.warm_limit         <= $signed(csr_wdata[11:0]);
            CSR_HOT_LIMIT:          cfg_ff.hot_limit          <= $signed(csr_wdata[11:0]);
            CSR_OVERHEAT_LIMIT:     cfg_ff.overheat_limit     <= $signed(csr_wdata[11:0]);
            CSR_STOP_VOLTAGE_UV:    cfg_ff.stop_voltage_uv    <= csr_wdata[22:0];
            CSR_REDUCED_CURRENT_MA: cfg_ff.reduced_current_ma <= csr_wdata[11:0];
            CSR_DEFAULT_CURRENT_MA: cfg_ff.default_current_ma <= csr_wdata[11:0];
            default: begin
            end
         endcase
      end
   end

   // Control state: stage valids and charge context
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         ctx_ff.mode         <= MODE_NORMAL;
         ctx_ff.last_charger <= 1'b0;
         ctx_ff.pseudo_flag  <= 1'b0;
         ctx_ff.last_current <= 12'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // Commit the context together with the result it produced
         if (advance) begin
            ctx_ff <= ctx_in;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_sample_ff.temp_dc          <= req_temp_dc;
         in_sample_ff.volt_uv          <= req_volt_uv;
         in_sample_ff.charger_present  <= req_charger_present;
         in_sample_ff.charger_changed  <= req_charger_changed;
         in_sample_ff.thermal_limit_ma <= req_thermal_limit_ma;
         in_sample_ff.charger_limit_ma <= req_charger_limit_ma;
      end
      if (advance) begin
         rsp_result_ff <= step_result;
      end
   end

   btcc_step u_step (
      .cfg    (cfg_ff),
      .ctx    (ctx_ff),
      .sample (in_sample_ff),
      .ctx_in (ctx_in),
      .result (step_result)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_charge_state     = rsp_result_ff.charge_state;
   assign rsp_transition       = rsp_result_ff.transition;
   assign rsp_refresh          = rsp_result_ff.refresh;
   assign rsp_disable_charge   = rsp_result_ff.disable_charge;
   assign rsp_current_limit_ma = rsp_result_ff.current_limit_ma;
   assign rsp_health           = rsp_result_ff.health;
   assign rsp_pseudo_charging  = rsp_result_ff.pseudo_charging;
   assign rsp_temp_band        = rsp_result_ff.temp_band;

   // Hold the charge context while a sample waits behind a stalled result
   a_ctx_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(ctx_ff))
      else $error("charge context changed while the result was stalled");

   // The shown current limit is the one remembered for change detection
   a_current_matches_ctx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_current_limit_ma == ctx_ff.last_current))
      else $error("result current limit differs from stored current");

   // A stop transition lands in the stopped state
   a_stop_transition: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_transition == TRANS_NORMAL_STOP ||
                        rsp_transition == TRANS_REDUCED_STOP))
      |-> (rsp_charge_state == MODE_STOPPED && rsp_disable_charge))
      else $error("stop transition without stopped state");

   // The shown state is the committed context state
   a_state_matches_ctx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_charge_state == ctx_ff.mode))
      else $error("result state differs from committed state");

endmodule

@@ hw/rtl/btcc_step.sv @@
// Per-sample band sort, charge state update and result selection.
module btcc_step import btcc_pkg::*; (
   input  cfg_type    cfg,
   input  ctx_type    ctx,
   input  sample_type sample,
   output ctx_type    ctx_in,
   output result_type result
);

   always_comb begin
      logic       event_seen;
      logic       plug_in;
      logic       over;
      logic       extreme;
      logic [2:0] band;
      mode_type   mode;
      trans_type  trans;
      logic       pseudo;
      logic [11:0] cur;

      event_seen = (ctx.last_charger != sample.charger_present) || sample.charger_changed;
      plug_in    = event_seen && sample.charger_present;
      over       = sample.volt_uv > cfg.stop_voltage_uv;

      // Test from the top band down so unordered thresholds still resolve
      if ($signed(sample.temp_dc) >= $signed(cfg.overheat_limit)) begin
         band = BAND_OVERHEAT;
      end else if ($signed(sample.temp_dc) >= $signed(cfg.hot_limit)) begin
         band = BAND_HOT;
      end else if ($signed(sample.temp_dc) >= $signed(cfg.warm_limit)) begin
         band = BAND_WARM;
      end else if ($signed(sample.temp_dc) >= $signed(cfg.cool_limit)) begin
         band = BAND_NORMAL;
      end else if ($signed(sample.temp_dc) >= $signed(cfg.cold_limit)) begin
         band = BAND_COOL;
      end else begin
         band = BAND_TOO_COLD;
      end
      extreme = (band == BAND_OVERHEAT) || (band == BAND_TOO_COLD);

      mode   = plug_in ? MODE_NORMAL : ctx.mode;
      trans  = TRANS_NONE;
      pseudo = ctx.pseudo_flag;

      case (mode)
         MODE_NORMAL: begin
            if (extreme) begin
               trans  = TRANS_NORMAL_STOP;
               pseudo = (band == BAND_TOO_COLD);
               mode   = MODE_STOPPED;
            end else if (band == BAND_HOT) begin
               if (over) begin
                  trans  = TRANS_NORMAL_STOP;
                  pseudo = 1'b1;
                  mode   = MODE_STOPPED;
               end else begin
                  trans  = TRANS_NORMAL_REDUCED;
                  pseudo = 1'b0;
                  mode   = MODE_REDUCED;
               end
            end
         end
         MODE_REDUCED: begin
            if (extreme) begin
               trans  = TRANS_REDUCED_STOP;
               pseudo = (band == BAND_TOO_COLD);
               mode   = MODE_STOPPED;
            end else if (over) begin
               trans  = TRANS_REDUCED_STOP;
               pseudo = 1'b1;
               mode   = MODE_STOPPED;
            end else if (band <= BAND_NORMAL) begin
               trans  = TRANS_REDUCED_NORMAL;
               pseudo = 1'b0;
               mode   = MODE_NORMAL;
            end
         end
         MODE_STOPPED: begin
            if (band == BAND_NORMAL) begin
               trans  = TRANS_STOP_NORMAL;
               pseudo = 1'b0;
               mode   = MODE_NORMAL;
            end else if (band == BAND_OVERHEAT) begin
               pseudo = 1'b0;
            end
         end
         default: begin
         end
      endcase

      case (mode)
         MODE_NORMAL: begin
            cur = (sample.thermal_limit_ma <= sample.charger_limit_ma) ?
                  sample.thermal_limit_ma : sample.charger_limit_ma;
         end
         MODE_REDUCED: begin
            cur = (sample.thermal_limit_ma <= cfg.reduced_current_ma) ?
                  sample.thermal_limit_ma : cfg.reduced_current_ma;
         end
         default: begin
            cur = cfg.default_current_ma;
         end
      endcase

      ctx_in.mode         = mode;
      ctx_in.last_charger = event_seen ? sample.charger_present : ctx.last_charger;
      ctx_in.pseudo_flag  = pseudo;
      ctx_in.last_current = cur;

      // The previous pseudo flag always equals the stored one, so compare against it
      result.charge_state     = mode;
      result.transition       = trans;
      result.refresh          = plug_in || (ctx.last_current != cur) ||
                                (ctx.pseudo_flag != pseudo);
      result.disable_charge   = (mode == MODE_STOPPED);
      result.current_limit_ma = cur;
      result.health           = (band == BAND_OVERHEAT) ? HEALTH_OVERHEAT :
                                ((band == BAND_TOO_COLD) ? HEALTH_COLD : HEALTH_GOOD);
      result.pseudo_charging  = pseudo;
      result.temp_band        = band;
   end

endmodule

@@ bench/battery_thermal_charge_control_checker.sv @@
// Checker for the battery thermal charge control block: predicts each result and compares it.
module battery_thermal_charge_control_checker import btcc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [11:0]         req_temp_dc,
   input  logic [22:0]                req_volt_uv,
   input  logic                       req_charger_present,
   input  logic                       req_charger_changed,
   input  logic [11:0]                req_thermal_limit_ma,
   input  logic [11:0]                req_charger_limit_ma,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [1:0]                 rsp_charge_state,
   input  logic [2:0]                 rsp_transition,
   input  logic                       rsp_refresh,
   input  logic                       rsp_disable_charge,
   input  logic [11:0]                rsp_current_limit_ma,
   input  logic [1:0]                 rsp_health,
   input  logic                       rsp_pseudo_charging,
   input  logic [2:0]                 rsp_temp_band,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                         fail_count,
   output int                         due_count
);

   // Shadow copy of the register file
   logic signed [11:0] cold_lim;
   logic signed [11:0] cool_lim;
   logic signed [11:0] warm_lim;
   logic signed [11:0] hot_lim;
   logic signed [11:0] overheat_lim;
   logic [22:0]        stop_uv;
   logic [11:0]        reduced_ma;
   logic [11:0]        fallback_ma;

   // Shadow copy of the charge machine
   mode_type           charge_mode;
   logic               charger_seen;
   logic               pseudo_on;
   logic               pseudo_reported;
   logic [11:0]        current_reported;

   result_type         charge_decisions_due[$];

   function automatic result_type decide_charge(input sample_type s);
      result_type  r;
      logic [2:0]  band;
      logic        over;
      logic        extreme;
      logic [11:0] cur;
      r = '0;
      r.transition = TRANS_NONE;
      over = s.volt_uv > stop_uv;

      // A charger event re-arms the machine when a charger is attached
      if (charger_seen != s.charger_present || s.charger_changed) begin
         charger_seen = s.charger_present;
         if (s.charger_present) begin
            charge_mode = MODE_NORMAL;
            r.refresh = 1'b1;
         end
      end

      // Test bands from the top down so non-ascending thresholds still resolve
      if ($signed(s.temp_dc) >= overheat_lim)      band = BAND_OVERHEAT;
      else if ($signed(s.temp_dc) >= hot_lim)      band = BAND_HOT;
      else if ($signed(s.temp_dc) >= warm_lim)     band = BAND_WARM;
      else if ($signed(s.temp_dc) >= cool_lim)     band = BAND_NORMAL;
      else if ($signed(s.temp_dc) >= cold_lim)     band = BAND_COOL;
      else                                         band = BAND_TOO_COLD;
      extreme = (band == BAND_OVERHEAT) || (band == BAND_TOO_COLD);

      case (charge_mode)
         MODE_NORMAL: begin
            if (extreme) begin
               r.transition = TRANS_NORMAL_STOP;
               pseudo_on = (band == BAND_TOO_COLD);
               charge_mode = MODE_STOPPED;
            end else if (band == BAND_HOT) begin
               if (over) begin
                  r.transition = TRANS_NORMAL_STOP;
                  pseudo_on = 1'b1;
                  charge_mode = MODE_STOPPED;
               end else begin
                  r.transition = TRANS_NORMAL_REDUCED;
                  pseudo_on = 1'b0;
                  charge_mode = MODE_REDUCED;
               end
            end
         end
         MODE_REDUCED: begin
            if (extreme) begin
               r.transition = TRANS_REDUCED_STOP;
               pseudo_on = (band == BAND_TOO_COLD);
               charge_mode = MODE_STOPPED;
            end else if (over) begin
               r.transition = TRANS_REDUCED_STOP;
               pseudo_on = 1'b1;
               charge_mode = MODE_STOPPED;
            end else if (band <= BAND_NORMAL) begin
               r.transition = TRANS_REDUCED_NORMAL;
               pseudo_on = 1'b0;
               charge_mode = MODE_NORMAL;
            end
         end
         MODE_STOPPED: begin
            if (band == BAND_NORMAL) begin
               r.transition = TRANS_STOP_NORMAL;
               pseudo_on = 1'b0;
               charge_mode = MODE_NORMAL;
            end else if (band == BAND_OVERHEAT) begin
               pseudo_on = 1'b0;
            end
         end
         default: ;
      endcase

      if (charge_mode == MODE_NORMAL)
         cur = (s.thermal_limit_ma <= s.charger_limit_ma) ? s.thermal_limit_ma
                                                          : s.charger_limit_ma;
      else if (charge_mode == MODE_REDUCED)
         cur = (s.thermal_limit_ma <= reduced_ma) ? s.thermal_limit_ma : reduced_ma;
      else
         cur = fallback_ma;

      if (current_reported != cur) begin
         current_reported = cur;
         r.refresh = 1'b1;
      end
      if (pseudo_reported != pseudo_on) begin
         pseudo_reported = pseudo_on;
         r.refresh = 1'b1;
      end

      r.charge_state     = charge_mode;
      r.disable_charge   = (charge_mode == MODE_STOPPED);
      r.current_limit_ma = cur;
      r.health           = (band == BAND_OVERHEAT) ? HEALTH_OVERHEAT :
                           (band == BAND_TOO_COLD) ? HEALTH_COLD : HEALTH_GOOD;
      r.pseudo_charging  = pseudo_on;
      r.temp_band        = band;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      sample_type smp;
      if (reset) begin
         cold_lim         = RST_COLD_LIMIT;
         cool_lim         = RST_COOL_LIMIT;
         warm_lim         = RST_WARM_LIMIT;
         hot_lim          = RST_HOT_LIMIT;
         overheat_lim     = RST_OVERHEAT_LIMIT;
         stop_uv          = RST_STOP_VOLTAGE_UV;
         reduced_ma       = RST_REDUCED_CURRENT_MA;
         fallback_ma      = RST_DEFAULT_CURRENT_MA;
         charge_mode      = MODE_NORMAL;
         charger_seen     = 1'b0;
         pseudo_on        = 1'b0;
         pseudo_reported  = 1'b0;
         current_reported = '0;
         charge_decisions_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COLD_LIMIT:         cold_lim     = csr_wdata[11:0];
               CSR_COOL_LIMIT:         cool_lim     = csr_wdata[11:0];
               CSR_WARM_LIMIT:         warm_lim     = csr_wdata[11:0];
               CSR_HOT_LIMIT:          hot_lim      = csr_wdata[11:0];
               CSR_OVERHEAT_LIMIT:     overheat_lim = csr_wdata[11:0];
               CSR_STOP_VOLTAGE_UV:    stop_uv      = csr_wdata;
               CSR_REDUCED_CURRENT_MA: reduced_ma   = csr_wdata[11:0];
               CSR_DEFAULT_CURRENT_MA: fallback_ma  = csr_wdata[11:0];
               default: ;
            endcase
         end

         // Retire before predicting so an empty store is caught
         if (rsp_valid && rsp_ready) begin
            if (charge_decisions_due.size() == 0) begin
               $error("result with no expectation waiting");
               fail_count = fail_count + 1;
            end else begin
               want = charge_decisions_due.pop_front();
               if (rsp_charge_state !== want.charge_state) begin
                  $error("charge_state: expected %0d, actual %0d",
                         want.charge_state, rsp_charge_state);
                  fail_count = fail_count + 1;
               end
               if (rsp_transition !== want.transition) begin
                  $error("transition: expected %0d, actual %0d",
                         want.transition, rsp_transition);
                  fail_count = fail_count + 1;
               end
               if (rsp_refresh !== want.refresh) begin
                  $error("refresh: expected %0d, actual %0d",
                         want.refresh, rsp_refresh);
                  fail_count = fail_count + 1;
               end
               if (rsp_disable_charge !== want.disable_charge) begin
                  $error("disable_charge: expected %0d, actual %0d",
                         want.disable_charge, rsp_disable_charge);
                  fail_count = fail_count + 1;
               end
               if (rsp_current_limit_ma !== want.current_limit_ma) begin
                  $error("current_limit_ma: expected %0d, actual %0d",
                         want.current_limit_ma, rsp_current_limit_ma);
                  fail_count = fail_count + 1;
               end
               if (rsp_health !== want.health) begin
                  $error("health: expected %0d, actual %0d", want.health, rsp_health);
                  fail_count = fail_count + 1;
               end
               if (rsp_pseudo_charging !== want.pseudo_charging) begin
                  $error("pseudo_charging: expected %0d, actual %0d",
                         want.pseudo_charging, rsp_pseudo_charging);
                  fail_count = fail_count + 1;
               end
               if (rsp_temp_band !== want.temp_band) begin
                  $error("temp_band: expected %0d, actual %0d",
                         want.temp_band, rsp_temp_band);
                  fail_count = fail_count + 1;
               end
            end
         end

         if (req_valid && req_ready) begin
            smp.temp_dc          = req_temp_dc;
            smp.volt_uv          = req_volt_uv;
            smp.charger_present  = req_charger_present;
            smp.charger_changed  = req_charger_changed;
            smp.thermal_limit_ma = req_thermal_limit_ma;
            smp.charger_limit_ma = req_charger_limit_ma;
            charge_decisions_due.push_back(decide_charge(smp));
         end
      end
      due_count <= charge_decisions_due.size();
   end

endmodule

@@ bench/battery_thermal_charge_control_tb.sv @@
// Testbench top for the battery thermal charge control block: stimulus, pacing and verdict.
module battery_thermal_charge_control_tb import btcc_pkg::*;;

   localparam int LONG_HOLD      = 300;   // receiver hold-off that backs up the pipe
   localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transaction
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 250;

   logic                       clock = 1'b0;
   logic                       reset;

   logic                       req_valid;
   logic                       req_ready;
   logic signed [11:0]         req_temp_dc;
   logic [22:0]                req_volt_uv;
   logic                       req_charger_present;
   logic                       req_charger_changed;
   logic [11:0]                req_thermal_limit_ma;
   logic [11:0]                req_charger_limit_ma;

   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [1:0]                 rsp_charge_state;
   logic [2:0]                 rsp_transition;
   logic                       rsp_refresh;
   logic                       rsp_disable_charge;
   logic [11:0]                rsp_current_limit_ma;
   logic [1:0]                 rsp_health;
   logic                       rsp_pseudo_charging;
   logic [2:0]                 rsp_temp_band;

   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   int                         fail_count;
   int                         due_count;
   int                         quiet_cycles;

   // Handshakes between the sender and receiver processes
   bit                         quiet_tail;
   bit                         hold_off_request;
   bit                         hold_off_done;

   battery_thermal_charge_control i_dut (.*);

   battery_thermal_charge_control_checker i_checker (.*);

   always #10 clock = ~clock;

   // Offer one sample and hold it until the block takes the transaction.
   task automatic offer(input int temp, input int volt, input bit present, input bit changed,
                        input int therm, input int chg);
      req_valid            <= 1'b1;
      req_temp_dc          <= temp[11:0];
      req_volt_uv          <= volt[22:0];
      req_charger_present  <= present;
      req_charger_changed  <= changed;
      req_thermal_limit_ma <= therm[11:0];
      req_charger_limit_ma <= chg[11:0];
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
      repeat (4) @(posedge clock);
   endtask

   // Receiver: random ready bursts and stalls, one long hold-off on request,
   // and a steady ready once the quiet tail starts.
   initial begin
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_request && !hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_done = 1'b1;
         end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("battery_thermal_charge_control: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sender: reset, directed samples, then configured phases of random samples.
   initial begin
      int phase;
      int n;
      int i;
      int t;
      int v;
      int pick;
      bit present;
      int therm;
      int chg;
      int setting[8];

      reset                = 1'b1;
      req_valid            = 1'b0;
      req_temp_dc          = '0;
      req_volt_uv          = '0;
      req_charger_present  = 1'b0;
      req_charger_changed  = 1'b0;
      req_thermal_limit_ma = '0;
      req_charger_limit_ma = '0;
      csr_we               = 1'b0;
      csr_index            = CSR_COLD_LIMIT;
      csr_wdata            = '0;
      quiet_tail           = 1'b0;
      hold_off_request     = 1'b0;
      hold_off_done        = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk under reset thresholds: every transition, band edges,
      // charger plug, unplug and change events, voltage and current extremes.
      offer(0, 3800000, 1, 0, 4095, 0);         // plug in, normal
      offer(450, 3800000, 1, 0, 4095, 0);       // warm, hold normal
      offer(470, 3900000, 1, 0, 300, 4095);     // hot, normal to reduced
      offer(450, 3900000, 1, 0, 4095, 4095);    // warm, hold reduced, capped current
      offer(470, 4100000, 1, 0, 4095, 4095);    // over voltage, reduced to stop
      offer(600, 4100000, 1, 0, 4095, 4095);    // overheat while stopped drops pseudo
      offer(-60, 3500000, 1, 0, 4095, 4095);    // cool while stopped, hold
      offer(0, 3500000, 1, 0, 1200, 2000);      // stop to normal
      offer(-2048, 3500000, 1, 0, 1200, 2000);  // coldest, normal to stop
      offer(-49, 3500000, 1, 0, 1200, 2000);    // exact cool edge, stop to normal
      offer(460, 4000001, 1, 0, 1200, 2000);    // exact hot edge, just over voltage
      offer(470, 4000000, 1, 1, 1200, 2000);    // change event, voltage at threshold
      offer(2047, 0, 1, 0, 0, 0);               // hottest, reduced to stop
      offer(2047, 0, 0, 0, 0, 0);               // unplug, stay stopped
      offer(600, 8000000, 1, 0, 0, 0);          // plug in forces normal, then stop
      offer(20, 8000000, 1, 0, 0, 4095);        // stop to normal
      offer(459, 8000000, 1, 0, 0, 4095);       // just below hot edge
      offer(470, 0, 1, 0, 4095, 4095);          // normal to reduced
      offer(-71, 0, 1, 0, 4095, 4095);          // just below cold edge, reduced to stop
      offer(-70, 0, 1, 1, 4095, 4095);          // change event at cold edge
      offer(470, 1000000, 1, 0, 4095, 4095);    // normal to reduced
      offer(-70, 1000000, 1, 0, 4095, 4095);    // cool band, reduced to normal
      offer(559, 4000000, 1, 0, 4095, 4095);    // just below overheat edge
      offer(440, 6000000, 1, 0, 4095, 4095);    // warm but over voltage, reduced to stop
      offer(500, 6000000, 0, 1, 4095, 4095);    // change event with no charger

      present = 1'b1;
      therm   = 1000;
      chg     = 1500;
      for (phase = 0; phase < PHASES; phase++) begin
         drain();

         // Pick the register set for this phase
         case (phase)
            0: begin
               setting[CSR_COLD_LIMIT]         = -100;
               setting[CSR_COOL_LIMIT]         = -50;
               setting[CSR_WARM_LIMIT]         = 450;
               setting[CSR_HOT_LIMIT]          = 470;
               setting[CSR_OVERHEAT_LIMIT]     = 600;
               setting[CSR_STOP_VOLTAGE_UV]    = 4100000;
               setting[CSR_REDUCED_CURRENT_MA] = 500;
               setting[CSR_DEFAULT_CURRENT_MA] = 800;
            end
            1: begin
               for (i = CSR_COLD_LIMIT; i <= CSR_OVERHEAT_LIMIT; i++) setting[i] = -2048;
               setting[CSR_STOP_VOLTAGE_UV]    = 0;
               setting[CSR_REDUCED_CURRENT_MA] = 0;
               setting[CSR_DEFAULT_CURRENT_MA] = 0;
            end
            2: begin
               for (i = CSR_COLD_LIMIT; i <= CSR_OVERHEAT_LIMIT; i++) setting[i] = 2047;
               setting[CSR_STOP_VOLTAGE_UV]    = 8000000;
               setting[CSR_REDUCED_CURRENT_MA] = 4095;
               setting[CSR_DEFAULT_CURRENT_MA] = 4095;
            end
            3: begin
               // Thresholds in no particular order
               for (i = CSR_COLD_LIMIT; i <= CSR_OVERHEAT_LIMIT; i++)
                  setting[i] = int'($urandom_range(0, 1500)) - 600;
               setting[CSR_STOP_VOLTAGE_UV]    = $urandom_range(0, 8000000);
               setting[CSR_REDUCED_CURRENT_MA] = $urandom_range(0, 4095);
               setting[CSR_DEFAULT_CURRENT_MA] = $urandom_range(0, 4095);
            end
            default: begin
               // Ascending thresholds, equal neighbors allowed
               setting[CSR_COLD_LIMIT] = int'($urandom_range(0, 600)) - 800;
               for (i = CSR_COOL_LIMIT; i <= CSR_OVERHEAT_LIMIT; i++)
                  setting[i] = setting[i-1] + int'($urandom_range(0, 300));
               setting[CSR_STOP_VOLTAGE_UV]    = $urandom_range(3000000, 5000000);
               setting[CSR_REDUCED_CURRENT_MA] = $urandom_range(0, 4095);
               setting[CSR_DEFAULT_CURRENT_MA] = $urandom_range(0, 4095);
            end
         endcase

         // Write every register back to back while the block is idle
         for (i = 0; i < $size(setting); i++) begin
            csr_we    <= 1'b1;
            csr_index <= CSR_INDEX_WIDTH'(i);
            csr_wdata <= setting[i][CSR_DATA_WIDTH-1:0];
            @(posedge clock);
         end
         csr_we <= 1'b0;

         quiet_tail = (phase == PHASES - 1);

         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Ask the receiver for its long hold-off midway through a phase
            if (phase == 4 && n == 100) hold_off_request = 1'b1;

            if (!quiet_tail && $urandom_range(0, 9) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end

            // Temperature: mostly around a threshold, some spread, a few anywhere
            pick = $urandom_range(0, 9);
            if (pick < 6)
               t = setting[$urandom_range(CSR_COLD_LIMIT, CSR_OVERHEAT_LIMIT)]
                   + int'($urandom_range(0, 8)) - 4;
            else if (pick < 9)
               t = int'($urandom_range(0, 1199)) - 400;
            else
               t = int'($urandom_range(0, 4095)) - 2048;
            if (t < -2048) t = -2048;
            if (t > 2047) t = 2047;

            // Voltage: often near the stop threshold, else anywhere in range
            pick = $urandom_range(0, 9);
            if (pick < 5)
               v = setting[CSR_STOP_VOLTAGE_UV] + int'($urandom_range(0, 4000)) - 2000;
            else if (pick < 6)
               v = setting[CSR_STOP_VOLTAGE_UV] + int'($urandom_range(0, 1));
            else
               v = $urandom_range(0, 8000000);
            if (v < 0) v = 0;
            if (v > 8000000) v = 8000000;

            // Charger mostly steady so the machine can advance between events
            if ($urandom_range(0, 99) < 6) present = ~present;
            if ($urandom_range(0, 9) < 3) therm = $urandom_range(0, 4095);
            if ($urandom_range(0, 9) < 3) chg = $urandom_range(0, 4095);

            offer(t, v, present, ($urandom_range(0, 99) < 5), therm, chg);
         end
      end

      drain();
      if (fail_count == 0)
         $display("battery_thermal_charge_control: match");
      else
         $display("battery_thermal_charge_control: mismatch");
      $finish;
   end

endmodule

@@ battery_thermal_charge_control.f @@
hw/rtl/btcc_pkg.sv
hw/rtl/btcc_step.sv
hw/rtl/battery_thermal_charge_control.sv
bench/battery_thermal_charge_control_checker.sv
bench/battery_thermal_charge_control_tb.sv
